/* src/v3alu_pkg.sv */
// ============================================================================
// Vector ALU package
// Word format, opcodes, pipeline depths and the saturating clamp shared by
// the lanes, the square-root pipeline, the divider lanes and the top level.
// ============================================================================
package v3alu_pkg;

  localparam int WordBits   = 32;
  localparam int FracBits   = 16;
  localparam int ProdBits   = 2 * WordBits;
  localparam int WideBits   = 2 * WordBits + 2;
  localparam int DivBits    = WordBits + FracBits;
  localparam int SqStages   = WordBits;
  localparam int DivStages  = DivBits;
  localparam int RemBits    = WordBits + 4;
  localparam int PipeStages = 2 + SqStages + DivStages;

  typedef logic signed [WordBits-1:0] word_t;

  localparam word_t WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordBits-1){1'b0}}};

  localparam logic signed [WideBits-1:0] WideMax =
    {{(WideBits-WordBits+1){1'b0}}, {(WordBits-1){1'b1}}};
  localparam logic signed [WideBits-1:0] WideMin =
    {{(WideBits-WordBits+1){1'b1}}, {(WordBits-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_ADDS  = 4'd2,
    OP_SUBS  = 4'd3,
    OP_SCALE = 4'd4,
    OP_DIV   = 4'd5,
    OP_NEG   = 4'd6,
    OP_DOT   = 4'd7,
    OP_CROSS = 4'd8,
    OP_LEN   = 4'd9,
    OP_NORM  = 4'd10
  } op_e;

  typedef struct packed {
    logic  sat;
    word_t val;
  } clamp_t;

  // Data that travels alongside the square-root and divider pipelines.
  typedef struct packed {
    op_e         op;
    word_t [2:0] a;
    word_t [2:0] r;
    word_t       rs;
    word_t       s;
    logic        dz;
    logic        sat;
    logic        use_q;
  } side_t;

  // Clamps a wide signed value to the word range and reports the clamp.
  function automatic clamp_t sat_word(input logic signed [WideBits-1:0] v);
    clamp_t res;
    if (v > WideMax) begin
      res.sat = 1'b1;
      res.val = WordMax;
    end else if (v < WideMin) begin
      res.sat = 1'b1;
      res.val = WordMin;
    end else begin
      res.sat = 1'b0;
      res.val = v[WordBits-1:0];
    end
    return res;
  endfunction

endpackage

/* src/v3alu_lane.sv */
// ============================================================================
// Vector ALU component lane
// Two-stage lane for one vector component: element-wise operations, the
// scaled product, the cross-product term and the products for dot and length.
// ============================================================================
module v3alu_lane (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  v3alu_pkg::op_e                            op_i,
  input  v3alu_pkg::word_t                          a_i,
  input  v3alu_pkg::word_t                          b_i,
  input  v3alu_pkg::word_t                          s_i,
  input  v3alu_pkg::word_t                          c1a_i,
  input  v3alu_pkg::word_t                          c1b_i,
  input  v3alu_pkg::word_t                          c2a_i,
  input  v3alu_pkg::word_t                          c2b_i,
  output logic signed [v3alu_pkg::ProdBits-1:0]     prod_dot_o,
  output logic signed [v3alu_pkg::ProdBits-1:0]     prod_sq_o,
  output v3alu_pkg::word_t                          a_o,
  output v3alu_pkg::word_t                          res_o,
  output logic                                      sat_o
);

  logic signed [v3alu_pkg::WordBits:0]   sum;
  v3alu_pkg::clamp_t                     simple_c;

  v3alu_pkg::op_e                        op0_q;
  v3alu_pkg::word_t                      a0_q;
  logic                                  szero0_q;
  v3alu_pkg::clamp_t                     simple_q;
  logic signed [v3alu_pkg::ProdBits-1:0] psc_q, pdot_q, psq_q, pc1_q, pc2_q;

  logic signed [v3alu_pkg::ProdBits:0]   cdiff;
  v3alu_pkg::clamp_t                     scale_c, cross_c;
  v3alu_pkg::word_t                      res_d;
  logic                                  sat_d;

  v3alu_pkg::word_t                      a1_q, res_q;
  logic                                  sat_q;

  // Element-wise operations on a 33-bit sum, clamped in the first stage.
  always_comb begin
    unique case (op_i)
      v3alu_pkg::OP_ADD:  sum = (v3alu_pkg::WordBits+1)'(a_i) + (v3alu_pkg::WordBits+1)'(b_i);
      v3alu_pkg::OP_SUB:  sum = (v3alu_pkg::WordBits+1)'(a_i) - (v3alu_pkg::WordBits+1)'(b_i);
      v3alu_pkg::OP_ADDS: sum = (v3alu_pkg::WordBits+1)'(a_i) + (v3alu_pkg::WordBits+1)'(s_i);
      v3alu_pkg::OP_SUBS: sum = (v3alu_pkg::WordBits+1)'(a_i) - (v3alu_pkg::WordBits+1)'(s_i);
      v3alu_pkg::OP_NEG:  sum = -(v3alu_pkg::WordBits+1)'(a_i);
      default:            sum = '0;
    endcase
    simple_c = v3alu_pkg::sat_word(v3alu_pkg::WideBits'(sum));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op0_q    <= op_i;
      a0_q     <= a_i;
      szero0_q <= (s_i == '0);
      simple_q <= simple_c;
      psc_q    <= a_i * s_i;
      pdot_q   <= a_i * b_i;
      psq_q    <= a_i * a_i;
      pc1_q    <= c1a_i * c1b_i;
      pc2_q    <= c2a_i * c2b_i;
    end
  end

  // Second stage: drop the fraction bits (floor) and pick the lane result.
  always_comb begin
    cdiff   = (v3alu_pkg::ProdBits+1)'(pc1_q) - (v3alu_pkg::ProdBits+1)'(pc2_q);
    scale_c = v3alu_pkg::sat_word(v3alu_pkg::WideBits'(psc_q >>> v3alu_pkg::FracBits));
    cross_c = v3alu_pkg::sat_word(v3alu_pkg::WideBits'(cdiff >>> v3alu_pkg::FracBits));
    res_d   = '0;
    sat_d   = 1'b0;
    unique case (op0_q)
      v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB, v3alu_pkg::OP_ADDS,
      v3alu_pkg::OP_SUBS, v3alu_pkg::OP_NEG: begin
        res_d = simple_q.val;
        sat_d = simple_q.sat;
      end
      v3alu_pkg::OP_SCALE: begin
        res_d = scale_c.val;
        sat_d = scale_c.sat;
      end
      v3alu_pkg::OP_CROSS: begin
        res_d = cross_c.val;
        sat_d = cross_c.sat;
      end
      v3alu_pkg::OP_DIV: begin
        if (szero0_q) begin
          res_d = a0_q[v3alu_pkg::WordBits-1] ? v3alu_pkg::WordMin : v3alu_pkg::WordMax;
          sat_d = 1'b1;
        end
      end
      v3alu_pkg::OP_NORM: res_d = a0_q;
      default: begin
        res_d = '0;
        sat_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= a0_q;
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign prod_dot_o = pdot_q;
  assign prod_sq_o  = psq_q;
  assign a_o        = a1_q;
  assign res_o      = res_q;
  assign sat_o      = sat_q;

endmodule

/* src/v3alu_sqrt.sv */
// ============================================================================
// Vector ALU square-root pipeline
// Integer square root of the sum of squares, one root bit per stage, with the
// item's side data carried along.
// ============================================================================
module v3alu_sqrt (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [v3alu_pkg::ProdBits-1:0]       rad_i,
  input  v3alu_pkg::side_t                     side_i,
  output logic [v3alu_pkg::WordBits-1:0]       root_o,
  output v3alu_pkg::side_t                     side_o
);

  logic [v3alu_pkg::RemBits-1:0]  rem_q  [v3alu_pkg::SqStages-1];
  logic [v3alu_pkg::ProdBits-1:0] rad_q  [v3alu_pkg::SqStages-1];
  logic [v3alu_pkg::WordBits-1:0] root_q [v3alu_pkg::SqStages];
  v3alu_pkg::side_t               side_q [v3alu_pkg::SqStages];

  for (genvar k = 0; k < v3alu_pkg::SqStages; k++) begin : g_stage
    logic [v3alu_pkg::RemBits-1:0]  rem_in, cat, trial;
    logic [v3alu_pkg::ProdBits-1:0] rad_in;
    logic [v3alu_pkg::WordBits-1:0] root_in;
    v3alu_pkg::side_t               sd_in;
    logic                           ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign sd_in   = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
      assign sd_in   = side_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign cat   = {rem_in[v3alu_pkg::RemBits-3:0], rad_in[v3alu_pkg::ProdBits-1 -: 2]};
    assign trial = v3alu_pkg::RemBits'({root_in, 2'b01});
    assign ge    = (cat >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_in[v3alu_pkg::WordBits-2:0], ge};
        side_q[k] <= sd_in;
      end
    end

    if (k < v3alu_pkg::SqStages - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? (cat - trial) : cat;
          rad_q[k] <= {rad_in[v3alu_pkg::ProdBits-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[v3alu_pkg::SqStages-1];
  assign side_o = side_q[v3alu_pkg::SqStages-1];

endmodule

/* src/v3alu_div_lane.sv */
// ============================================================================
// Vector ALU divider lane
// Restoring unsigned divider of the shifted component magnitude by the
// divisor, one quotient bit per stage; the quotient sign rides along.
// ============================================================================
module v3alu_div_lane (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [v3alu_pkg::WordBits-1:0]       dvd_i,
  input  logic [v3alu_pkg::WordBits-1:0]       dvs_i,
  input  logic                                 neg_i,
  output logic [v3alu_pkg::DivBits-1:0]        quo_o,
  output logic                                 neg_o
);

  logic [v3alu_pkg::WordBits-1:0] rem_q [v3alu_pkg::DivStages-1];
  logic [v3alu_pkg::WordBits-1:0] dvs_q [v3alu_pkg::DivStages-1];
  logic [v3alu_pkg::DivBits-1:0]  num_q [v3alu_pkg::DivStages];
  logic                           neg_q [v3alu_pkg::DivStages];

  for (genvar k = 0; k < v3alu_pkg::DivStages; k++) begin : g_stage
    logic [v3alu_pkg::WordBits-1:0] rem_in, dvs_in;
    logic [v3alu_pkg::DivBits-1:0]  num_in;
    logic                           neg_in, ge;
    logic [v3alu_pkg::WordBits:0]   cat, diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dvs_in = dvs_i;
      assign num_in = {dvd_i, {v3alu_pkg::FracBits{1'b0}}};
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign num_in = num_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign cat  = {rem_in, num_in[v3alu_pkg::DivBits-1]};
    assign diff = cat - {1'b0, dvs_in};
    assign ge   = (cat >= {1'b0, dvs_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= {num_in[v3alu_pkg::DivBits-2:0], ge};
        neg_q[k] <= neg_in;
      end
    end

    if (k < v3alu_pkg::DivStages - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? diff[v3alu_pkg::WordBits-1:0] : cat[v3alu_pkg::WordBits-1:0];
          dvs_q[k] <= dvs_in;
        end
      end
    end
  end

  assign quo_o = num_q[v3alu_pkg::DivStages-1];
  assign neg_o = neg_q[v3alu_pkg::DivStages-1];

endmodule

/* src/vector3_fixed_point_alu.sv */
// ============================================================================
// Three-component fixed-point vector ALU
// Pipelined Q16.16 vector unit: add, subtract, scalar add and subtract,
// scale, divide, negate, dot, cross, length and normalize, all saturating.
// ============================================================================
//
//  Channel | Direction | Handshake               | Beat contents
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o | req_type, a, b, scalar_in
//  out     | output    | out_valid_o / out_stall_i | r_x, r_y, r_z, r_scalar, flags
//
//  One beat is taken every cycle while in_stall_o is low; each result passes
//  the two lane stages, the 32-stage square-root pipeline, the 48-stage
//  quotient pipeline and the output register before it is valid on the
//  output.
//  Reset clears only the valid bits and the output and skid flags.
//  A stalled result sits in the output register and one more in a skid
//  register; in_stall_o is simply that skid register being full, and the
//  whole pipeline holds while it is.
//
module vector3_fixed_point_alu (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [3:0]              req_type_i,
  input  v3alu_pkg::word_t        a_x_i,
  input  v3alu_pkg::word_t        a_y_i,
  input  v3alu_pkg::word_t        a_z_i,
  input  v3alu_pkg::word_t        b_x_i,
  input  v3alu_pkg::word_t        b_y_i,
  input  v3alu_pkg::word_t        b_z_i,
  input  v3alu_pkg::word_t        scalar_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output v3alu_pkg::word_t        r_x_o,
  output v3alu_pkg::word_t        r_y_o,
  output v3alu_pkg::word_t        r_z_o,
  output v3alu_pkg::word_t        r_scalar_o,
  output logic                    div_zero_o,
  output logic                    saturated_o
);

  typedef struct packed {
    v3alu_pkg::word_t [2:0] r;
    v3alu_pkg::word_t       rs;
    logic                   dz;
    logic                   sat;
  } out_t;

  // The whole pipeline moves whenever the skid register is free.
  logic                                   adv;
  logic [v3alu_pkg::PipeStages-1:0]       vld_q;
  logic                                   out_v_q, skid_v_q;
  out_t                                   out_q, skid_q, fin;
  v3alu_pkg::op_e                         op_in;

  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;
  assign op_in      = v3alu_pkg::op_e'(req_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[v3alu_pkg::PipeStages-2:0], in_valid_i};
    end
  end

  // Lanes: one per component. Each lane also forms its cross-product term.
  logic signed [v3alu_pkg::ProdBits-1:0] pdot [3];
  logic signed [v3alu_pkg::ProdBits-1:0] psq  [3];
  v3alu_pkg::word_t                      la   [3];
  v3alu_pkg::word_t                      lres [3];
  logic [2:0]                            lsat;

  v3alu_lane u_lane_x (
    .clk_i, .en_i(adv), .op_i(op_in), .a_i(a_x_i), .b_i(b_x_i), .s_i(scalar_in_i),
    .c1a_i(a_y_i), .c1b_i(b_z_i), .c2a_i(a_z_i), .c2b_i(b_y_i),
    .prod_dot_o(pdot[0]), .prod_sq_o(psq[0]), .a_o(la[0]), .res_o(lres[0]), .sat_o(lsat[0])
  );

  v3alu_lane u_lane_y (
    .clk_i, .en_i(adv), .op_i(op_in), .a_i(a_y_i), .b_i(b_y_i), .s_i(scalar_in_i),
    .c1a_i(a_z_i), .c1b_i(b_x_i), .c2a_i(a_x_i), .c2b_i(b_z_i),
    .prod_dot_o(pdot[1]), .prod_sq_o(psq[1]), .a_o(la[1]), .res_o(lres[1]), .sat_o(lsat[1])
  );

  v3alu_lane u_lane_z (
    .clk_i, .en_i(adv), .op_i(op_in), .a_i(a_z_i), .b_i(b_z_i), .s_i(scalar_in_i),
    .c1a_i(a_x_i), .c1b_i(b_y_i), .c2a_i(a_y_i), .c2b_i(b_x_i),
    .prod_dot_o(pdot[2]), .prod_sq_o(psq[2]), .a_o(la[2]), .res_o(lres[2]), .sat_o(lsat[2])
  );

  // Opcode and scalar follow the lanes' two stages.
  v3alu_pkg::op_e                        op0_q, op1_q;
  v3alu_pkg::word_t                      s0_q, s1_q;
  logic signed [v3alu_pkg::WideBits-1:0] dot_sum;
  v3alu_pkg::clamp_t                     dot_c, dot_q;
  logic [v3alu_pkg::ProdBits-1:0]        sq_sum, sq_q;

  // The dot product is the exact sum of the three products, floored once.
  // The squares are nonnegative and their sum always fits the product width.
  assign dot_sum = v3alu_pkg::WideBits'(pdot[0]) + v3alu_pkg::WideBits'(pdot[1])
                 + v3alu_pkg::WideBits'(pdot[2]);
  assign dot_c   = v3alu_pkg::sat_word(dot_sum >>> v3alu_pkg::FracBits);
  assign sq_sum  = psq[0] + psq[1] + psq[2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op0_q <= op_in;
      s0_q  <= scalar_in_i;
      op1_q <= op0_q;
      s1_q  <= s0_q;
      dot_q <= dot_c;
      sq_q  <= sq_sum;
    end
  end

  // Merge what the lanes found into the side data for the long pipelines.
  v3alu_pkg::side_t sq_side_in;

  always_comb begin
    sq_side_in.op    = op1_q;
    sq_side_in.s     = s1_q;
    sq_side_in.dz    = (op1_q == v3alu_pkg::OP_DIV) && (s1_q == '0);
    sq_side_in.rs    = (op1_q == v3alu_pkg::OP_DOT) ? dot_q.val : '0;
    sq_side_in.sat   = (|lsat) || ((op1_q == v3alu_pkg::OP_DOT) && dot_q.sat);
    sq_side_in.use_q = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sq_side_in.a[i] = la[i];
      sq_side_in.r[i] = lres[i];
    end
  end

  logic [v3alu_pkg::WordBits-1:0] root;
  v3alu_pkg::side_t               sq_side_out;

  v3alu_sqrt u_sqrt (
    .clk_i,
    .en_i   (adv),
    .rad_i  (sq_q),
    .side_i (sq_side_in),
    .root_o (root),
    .side_o (sq_side_out)
  );

  // After the root: length result, and the divisor for divide or normalize.
  // A normalize of the zero vector keeps the vector the lanes passed through.
  v3alu_pkg::clamp_t              len_c;
  v3alu_pkg::side_t               div_side;
  logic [v3alu_pkg::WordBits-1:0] dvs;
  logic [v3alu_pkg::WordBits-1:0] dvd [3];
  logic [2:0]                     qneg_in;
  logic                           is_div;

  always_comb begin
    len_c    = v3alu_pkg::sat_word(v3alu_pkg::WideBits'({1'b0, root}));
    div_side = sq_side_out;
    is_div   = (sq_side_out.op == v3alu_pkg::OP_DIV);
    if (sq_side_out.op == v3alu_pkg::OP_LEN) begin
      div_side.rs  = len_c.val;
      div_side.sat = sq_side_out.sat || len_c.sat;
    end
    div_side.use_q = (is_div && !sq_side_out.dz)
                  || ((sq_side_out.op == v3alu_pkg::OP_NORM) && (root != '0));
    if (sq_side_out.op == v3alu_pkg::OP_NORM) begin
      dvs = root;
    end else begin
      dvs = sq_side_out.s[v3alu_pkg::WordBits-1] ? -sq_side_out.s : sq_side_out.s;
    end
    for (int i = 0; i < 3; i++) begin
      dvd[i]     = sq_side_out.a[i][v3alu_pkg::WordBits-1] ? -sq_side_out.a[i]
                                                            : sq_side_out.a[i];
      qneg_in[i] = sq_side_out.a[i][v3alu_pkg::WordBits-1]
                 ^ (is_div && sq_side_out.s[v3alu_pkg::WordBits-1]);
    end
  end

  logic [v3alu_pkg::DivBits-1:0] quo  [3];
  logic [2:0]                    qneg;

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3alu_div_lane u_div (
      .clk_i,
      .en_i  (adv),
      .dvd_i (dvd[i]),
      .dvs_i (dvs),
      .neg_i (qneg_in[i]),
      .quo_o (quo[i]),
      .neg_o (qneg[i])
    );
  end

  // Side data delay matching the divider depth.
  v3alu_pkg::side_t dsd_q [v3alu_pkg::DivStages];

  for (genvar k = 0; k < v3alu_pkg::DivStages; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dsd_q[k] <= (k == 0) ? div_side : dsd_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Final merge: quotients are signed, clamped and take the place of the
  // early vector when the item used the divider.
  v3alu_pkg::side_t                      fsd;
  logic signed [v3alu_pkg::WideBits-1:0] qw;
  v3alu_pkg::clamp_t                     qc;

  always_comb begin
    fsd     = dsd_q[v3alu_pkg::DivStages-1];
    fin.rs  = fsd.rs;
    fin.dz  = fsd.dz;
    fin.sat = fsd.sat;
    qw      = '0;
    qc      = '0;
    for (int i = 0; i < 3; i++) begin
      qw = v3alu_pkg::WideBits'({1'b0, quo[i]});
      if (qneg[i]) begin
        qw = -qw;
      end
      qc = v3alu_pkg::sat_word(qw);
      if (fsd.use_q) begin
        fin.r[i] = qc.val;
        fin.sat  = fin.sat || qc.sat;
      end else begin
        fin.r[i] = fsd.r[i];
      end
    end
  end

  // Output register plus skid register.
  logic ins, drain;

  assign ins   = vld_q[v3alu_pkg::PipeStages-1] && adv;
  assign drain = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (drain) begin
      out_v_q  <= skid_v_q || ins;
      skid_v_q <= 1'b0;
    end else if (ins) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (ins) begin
        out_q <= fin;
      end
    end else if (ins) begin
      skid_q <= fin;
    end
  end

  assign out_valid_o = out_v_q;
  assign r_x_o       = out_q.r[0];
  assign r_y_o       = out_q.r[1];
  assign r_z_o       = out_q.r[2];
  assign r_scalar_o  = out_q.rs;
  assign div_zero_o  = out_q.dz;
  assign saturated_o = out_q.sat;

  // A divide by zero always reports saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |-> saturated_o)
    else $error("divide by zero without saturation flag");

  // Scalar results come with a zero vector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (r_scalar_o != '0) |-> (r_x_o == '0) && (r_y_o == '0) && (r_z_o == '0))
    else $error("scalar result with nonzero vector");

  // The input only stalls when both output slots hold results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // The skid register fills only behind a stalled output beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("skid register filled without output stall");

endmodule

/* test/vector3_fixed_point_alu_checker.sv */
// ----------------------------------------------------------------------------
// Vector ALU result checker
// Watches both channels of the vector ALU and predicts each result from the
// accepted request. Results are compared field by field, in order, and every
// mismatch is counted.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [3:0]       req_type_i,
  input  v3alu_pkg::word_t a_x_i,
  input  v3alu_pkg::word_t a_y_i,
  input  v3alu_pkg::word_t a_z_i,
  input  v3alu_pkg::word_t b_x_i,
  input  v3alu_pkg::word_t b_y_i,
  input  v3alu_pkg::word_t b_z_i,
  input  v3alu_pkg::word_t scalar_in_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  v3alu_pkg::word_t r_x_i,
  input  v3alu_pkg::word_t r_y_i,
  input  v3alu_pkg::word_t r_z_i,
  input  v3alu_pkg::word_t r_scalar_i,
  input  logic             div_zero_i,
  input  logic             saturated_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    v3alu_pkg::word_t x;
    v3alu_pkg::word_t y;
    v3alu_pkg::word_t z;
    v3alu_pkg::word_t s;
    logic             dz;
    logic             sat;
  } vec_result_t;

  vec_result_t expected_results[$];

  function automatic v3alu_pkg::word_t clip(input wide_t v, inout logic sat);
    if (v > wide_t'(v3alu_pkg::WordMax)) begin
      sat = 1'b1;
      return v3alu_pkg::WordMax;
    end
    if (v < wide_t'(v3alu_pkg::WordMin)) begin
      sat = 1'b1;
      return v3alu_pkg::WordMin;
    end
    return v3alu_pkg::word_t'(v[v3alu_pkg::WordBits-1:0]);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] pos_bit;
    root    = '0;
    pos_bit = 64'd1 << 62;
    while (pos_bit > n) pos_bit = pos_bit >> 2;
    while (pos_bit != 0) begin
      if (n >= root + pos_bit) begin
        n    = n - (root + pos_bit);
        root = (root >> 1) + pos_bit;
      end else begin
        root = root >> 1;
      end
      pos_bit = pos_bit >> 2;
    end
    return root;
  endfunction

  // Quotient in Q16.16, truncated toward zero.
  function automatic wide_t fix_div(input wide_t num, input wide_t den);
    return (num <<< v3alu_pkg::FracBits) / den;
  endfunction

  function automatic vec_result_t vector_op(input logic [3:0] op,
                                            input v3alu_pkg::word_t a[3],
                                            input v3alu_pkg::word_t b[3],
                                            input v3alu_pkg::word_t s);
    vec_result_t res;
    wide_t       wa[3];
    wide_t       wb[3];
    wide_t       ws;
    wide_t       r[3];
    wide_t       acc;
    logic [63:0] len;
    logic        sat;
    sat = 1'b0;
    res = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      wa[i] = wide_t'(a[i]);
      wb[i] = wide_t'(b[i]);
      r[i]  = '0;
    end
    ws = wide_t'(s);
    case (op)
      v3alu_pkg::OP_ADD:   for (int i = 0; i < 3; i++) r[i] = wa[i] + wb[i];
      v3alu_pkg::OP_SUB:   for (int i = 0; i < 3; i++) r[i] = wa[i] - wb[i];
      v3alu_pkg::OP_ADDS:  for (int i = 0; i < 3; i++) r[i] = wa[i] + ws;
      v3alu_pkg::OP_SUBS:  for (int i = 0; i < 3; i++) r[i] = wa[i] - ws;
      v3alu_pkg::OP_SCALE:
        for (int i = 0; i < 3; i++) r[i] = (wa[i] * ws) >>> v3alu_pkg::FracBits;
      v3alu_pkg::OP_NEG:   for (int i = 0; i < 3; i++) r[i] = -wa[i];
      v3alu_pkg::OP_DIV: begin
        if (s == 0) begin
          res.dz = 1'b1;
          sat    = 1'b1;
          for (int i = 0; i < 3; i++) begin
            r[i] = (a[i] < 0) ? wide_t'(v3alu_pkg::WordMin) : wide_t'(v3alu_pkg::WordMax);
          end
        end else begin
          for (int i = 0; i < 3; i++) r[i] = fix_div(wa[i], ws);
        end
      end
      v3alu_pkg::OP_DOT: begin
        acc   = (wa[0] * wb[0] + wa[1] * wb[1] + wa[2] * wb[2]) >>> v3alu_pkg::FracBits;
        res.s = clip(acc, sat);
      end
      v3alu_pkg::OP_CROSS: begin
        r[0] = (wa[1] * wb[2] - wa[2] * wb[1]) >>> v3alu_pkg::FracBits;
        r[1] = (wa[2] * wb[0] - wa[0] * wb[2]) >>> v3alu_pkg::FracBits;
        r[2] = (wa[0] * wb[1] - wa[1] * wb[0]) >>> v3alu_pkg::FracBits;
      end
      v3alu_pkg::OP_LEN, v3alu_pkg::OP_NORM: begin
        acc = wa[0] * wa[0] + wa[1] * wa[1] + wa[2] * wa[2];
        len = int_sqrt(acc[63:0]);
        if (op == v3alu_pkg::OP_LEN) begin
          res.s = clip(wide_t'({64'd0, len}), sat);
        end else if (len == 0) begin
          for (int i = 0; i < 3; i++) r[i] = wa[i];
        end else begin
          for (int i = 0; i < 3; i++) r[i] = fix_div(wa[i], wide_t'({64'd0, len}));
        end
      end
      default: ;
    endcase
    res.x   = clip(r[0], sat);
    res.y   = clip(r[1], sat);
    res.z   = clip(r[2], sat);
    res.sat = sat;
    return res;
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    vec_result_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(vector_op(req_type_i, '{a_x_i, a_y_i, a_z_i},
                                             '{b_x_i, b_y_i, b_z_i}, scalar_in_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat", $realtime);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.x !== r_x_i || want.y !== r_y_i || want.z !== r_z_i ||
              want.s !== r_scalar_i || want.dz !== div_zero_i || want.sat !== saturated_i) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h s=%h dz=%b sat=%b", $realtime,
                     want.x, want.y, want.z, want.s, want.dz, want.sat);
            $display("%0t:          actual   x=%h y=%h z=%h s=%h dz=%b sat=%b", $realtime,
                     r_x_i, r_y_i, r_z_i, r_scalar_i, div_zero_i, saturated_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* test/vector3_fixed_point_alu_tb.sv */
// ----------------------------------------------------------------------------
// Vector ALU testbench
// Drives directed corner requests and then random requests into the vector
// ALU under random idling on both channels, and lets the checker compare
// every result beat against its own prediction.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes past normalize are unused and must return all zero.
  localparam logic [3:0] OpUnusedLo = 4'd11;
  localparam logic [3:0] OpUnusedHi = 4'd15;
  // This covers the tail of the block's pipeline with margin.
  localparam int DrainCycles = 200;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int HangLimit = 5000;
  localparam int RandomBeats = 400;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [3:0]       req_type;
  v3alu_pkg::word_t a_x, a_y, a_z, b_x, b_y, b_z, scalar_in;
  logic             out_valid;
  logic             out_stall;
  v3alu_pkg::word_t r_x, r_y, r_z, r_scalar;
  logic             div_zero;
  logic             saturated;
  int               fail_count;
  int               pending;

  // Idle percentages of the sender and of the receiver; changed per phase.
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  vector3_fixed_point_alu i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type),
    .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z),
    .b_x_i(b_x), .b_y_i(b_y), .b_z_i(b_z),
    .scalar_in_i(scalar_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .r_x_o(r_x), .r_y_o(r_y), .r_z_o(r_z), .r_scalar_o(r_scalar),
    .div_zero_o(div_zero), .saturated_o(saturated)
  );

  vector3_fixed_point_alu_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .req_type_i(req_type),
    .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z),
    .b_x_i(b_x), .b_y_i(b_y), .b_z_i(b_z),
    .scalar_in_i(scalar_in),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .r_x_i(r_x), .r_y_i(r_y), .r_z_i(r_z), .r_scalar_i(r_scalar),
    .div_zero_i(div_zero), .saturated_i(saturated),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Watchdog: any beat on either channel resets the count of quiet cycles.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HangLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Sends one request beat. Valid is raised at a rising edge and held until
  // the edge at which stall is low; stall is a register output, so it is
  // sampled at the falling edge where it is settled. Valid stays high after
  // the beat so that a following beat can go out back to back.
  task automatic send_request(input logic [3:0] op, input v3alu_pkg::word_t ax,
                              input v3alu_pkg::word_t ay, input v3alu_pkg::word_t az,
                              input v3alu_pkg::word_t bx, input v3alu_pkg::word_t by,
                              input v3alu_pkg::word_t bz, input v3alu_pkg::word_t s);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= op;
    a_x       <= ax;
    a_y       <= ay;
    a_z       <= az;
    b_x       <= bx;
    b_y       <= by;
    b_z       <= bz;
    scalar_in <= s;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Random word: full range, small Q16.16 values, a corner value or a shifted
  // random word, so that both saturation and exact arithmetic are exercised.
  function automatic v3alu_pkg::word_t rand_word();
    case ($urandom_range(0, 5))
      0, 1: return v3alu_pkg::word_t'($urandom);
      2, 3: return v3alu_pkg::word_t'($signed($urandom_range(0, 32'h0010_0000))
                                      - 32'sh0008_0000);
      4: begin
        case ($urandom_range(0, 4))
          0: return v3alu_pkg::WordMax;
          1: return v3alu_pkg::WordMin;
          2: return '0;
          3: return v3alu_pkg::word_t'(-1);
          default: return v3alu_pkg::word_t'(32'h0001_0000);
        endcase
      end
      default: return v3alu_pkg::word_t'($signed($urandom) >>> $urandom_range(8, 24));
    endcase
  endfunction

  task automatic send_random();
    logic [3:0]       op;
    v3alu_pkg::word_t ax, ay, az, s;
    op = ($urandom_range(0, 19) == 0)
       ? 4'($urandom_range(OpUnusedLo, OpUnusedHi))
       : 4'($urandom_range(v3alu_pkg::OP_ADD, v3alu_pkg::OP_NORM));
    ax = rand_word();
    ay = rand_word();
    az = rand_word();
    s  = rand_word();
    // Zero vectors for normalize and zero divisors need a push to show up.
    if (op == v3alu_pkg::OP_NORM && $urandom_range(0, 5) == 0) begin
      ax = '0;
      ay = '0;
      az = '0;
    end
    if (op == v3alu_pkg::OP_DIV && $urandom_range(0, 4) == 0) s = '0;
    send_request(op, ax, ay, az, rand_word(), rand_word(), rand_word(), s);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    req_type      = '0;
    a_x           = '0;
    a_y           = '0;
    a_z           = '0;
    b_x           = '0;
    b_y           = '0;
    b_z           = '0;
    scalar_in     = '0;
    send_idle_pct = 21;
    recv_idle_pct = 51;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: overflow in each direction, divide by zero for a
    // negative, zero and positive component, the zero vector in normalize,
    // full-range products and the unused opcodes.
    send_request(v3alu_pkg::OP_ADD, v3alu_pkg::WordMax, v3alu_pkg::WordMin, 1,
                 v3alu_pkg::WordMax, v3alu_pkg::WordMin, -1, 0);
    send_request(v3alu_pkg::OP_SUB, v3alu_pkg::WordMin, v3alu_pkg::WordMax, 0,
                 v3alu_pkg::WordMax, v3alu_pkg::WordMin, 0, 0);
    send_request(v3alu_pkg::OP_ADDS, v3alu_pkg::WordMax, v3alu_pkg::WordMin, 5, 0, 0, 0,
                 v3alu_pkg::WordMax);
    send_request(v3alu_pkg::OP_SUBS, v3alu_pkg::WordMin, v3alu_pkg::WordMax, -5, 0, 0, 0,
                 v3alu_pkg::WordMin);
    send_request(v3alu_pkg::OP_SCALE, v3alu_pkg::WordMin, v3alu_pkg::WordMax, -3, 0, 0, 0,
                 v3alu_pkg::WordMin);
    send_request(v3alu_pkg::OP_SCALE, 32'sh0001_8000, -32'sh0000_0001, 7, 0, 0, 0,
                 32'sh0000_8000);
    send_request(v3alu_pkg::OP_DIV, -7, 0, 9, 0, 0, 0, 0);
    send_request(v3alu_pkg::OP_DIV, v3alu_pkg::WordMin, v3alu_pkg::WordMax, 32'sh0003_0000,
                 0, 0, 0, 1);
    send_request(v3alu_pkg::OP_DIV, -32'sh0007_0000, 32'sh0001_0000, 5, 0, 0, 0,
                 32'sh0003_0000);
    send_request(v3alu_pkg::OP_NEG, v3alu_pkg::WordMin, v3alu_pkg::WordMax, 0, 0, 0, 0, 0);
    send_request(v3alu_pkg::OP_DOT, v3alu_pkg::WordMin, v3alu_pkg::WordMin,
                 v3alu_pkg::WordMin, v3alu_pkg::WordMin, v3alu_pkg::WordMin,
                 v3alu_pkg::WordMin, 0);
    send_request(v3alu_pkg::OP_DOT, v3alu_pkg::WordMax, -3, 1, v3alu_pkg::WordMin, 5, -1, 0);
    send_request(v3alu_pkg::OP_CROSS, v3alu_pkg::WordMax, v3alu_pkg::WordMin,
                 v3alu_pkg::WordMax, v3alu_pkg::WordMin, v3alu_pkg::WordMax,
                 v3alu_pkg::WordMin, 0);
    send_request(v3alu_pkg::OP_CROSS, 32'sh0001_0000, 3, -7, 11, -32'sh0002_0000, 5, 0);
    send_request(v3alu_pkg::OP_LEN, v3alu_pkg::WordMin, v3alu_pkg::WordMin,
                 v3alu_pkg::WordMin, 0, 0, 0, 0);
    send_request(v3alu_pkg::OP_LEN, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0);
    send_request(v3alu_pkg::OP_NORM, 0, 0, 0, 1, 2, 3, 4);
    send_request(v3alu_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0);
    send_request(v3alu_pkg::OP_NORM, v3alu_pkg::WordMin, v3alu_pkg::WordMax, -1, 0, 0, 0, 0);
    send_request(OpUnusedLo, v3alu_pkg::WordMax, v3alu_pkg::WordMin, 1, 2, 3, 4, 5);
    send_request(OpUnusedHi, -1, -1, -1, -1, -1, -1, -1);
    in_valid <= 1'b0;

    // Hold the sender off until the pipeline is empty.
    wait_drained();

    for (int n = 0; n < RandomBeats; n++) begin
      if (n == RandomBeats / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 21;
      end else if (n == 2 * RandomBeats / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random();
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
